>>> rtl/assert_macros.svh
// assertion macros for the rtl that checks itself; included by the top level only
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CTP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition must never be true outside reset
`define CTP_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

>>> rtl/ctp_pkg.sv
// shared types and codes of the ctaphid response packetizer
// no dependencies; used by the framer and the top level
`default_nettype none

package ctp_pkg;

    // input item commands
    localparam logic [1:0] CMD_HEADER  = 2'd0;
    localparam logic [1:0] CMD_PAYLOAD = 2'd1;
    localparam logic [1:0] CMD_REPORT  = 2'd2;

    // packet kinds on the output
    localparam logic [1:0] KIND_INITIAL = 2'd0;
    localparam logic [1:0] KIND_CONT    = 2'd1;
    localparam logic [1:0] KIND_BUSY    = 2'd2;

    // configuration register indexes
    localparam logic REG_ERROR_CMD = 1'b0;
    localparam logic REG_BUSY_CODE = 1'b1;

    // header byte counts of the three packet kinds
    localparam logic [3:0] HDR_LEN_INIT = 4'd7;
    localparam logic [3:0] HDR_LEN_CONT = 4'd5;
    localparam logic [3:0] HDR_LEN_BUSY = 4'd8;

    // widths that cover the full ranges of packet size and message size
    localparam int COUNT_W = 7;
    localparam int BASE_W  = 13;

    // one packet request from the control logic to the framer
    typedef struct packed {
        logic               start;
        logic [1:0]         kind;
        logic [7:0][7:0]    hdr;
        logic [3:0]         hdr_len;
        logic [COUNT_W-1:0] count;
        logic [BASE_W-1:0]  base;
    } pkt_req_t;

endpackage

`default_nettype wire

>>> rtl/ctp_if.sv
// valid/ready channel interfaces of the packetizer: input items and packet bytes
// no dependencies
`default_nettype none

interface ctp_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] channel_id;
    logic [6:0]  resp_command;
    logic [15:0] message_length;
    logic [7:0]  payload_byte;
    logic        endpoint_ok;

    modport source (
        output valid, cmd, channel_id, resp_command, message_length, payload_byte,
               endpoint_ok,
        input  ready
    );
    modport sink (
        input  valid, cmd, channel_id, resp_command, message_length, payload_byte,
               endpoint_ok,
        output ready
    );
endinterface

interface ctp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic [5:0] byte_index;
    logic [1:0] packet_kind;
    logic       last_byte;

    modport source (
        output valid, packet_byte, byte_index, packet_kind, last_byte,
        input  ready
    );
    modport sink (
        input  valid, packet_byte, byte_index, packet_kind, last_byte,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/ctp_ram.sv
// generic single-clock ram: one write port, one read port, registered read
// no dependencies
`default_nettype none

module ctp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/ctp_framer.sv
// packet framer: walks the byte positions of one packet, reads payload from the ram
// depends on ctp_pkg and ctp_byte_if
`default_nettype none

module ctp_framer #(
    parameter int PACKET_BYTES = 64,
    parameter int ADDR_W       = 13
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctp_pkg::pkt_req_t req,
    output logic                   idle,
    output logic                   ram_re,
    output logic      [ADDR_W-1:0] ram_raddr,
    input  wire logic [7:0]        ram_rdata,
    ctp_byte_if.source             tx
);

    import ctp_pkg::*;

    localparam int KW     = $clog2(PACKET_BYTES);
    localparam int LAST_K = PACKET_BYTES - 1;

    typedef enum logic [1:0] {SEL_ZERO, SEL_HDR, SEL_DATA} sel_t;

    pkt_req_t      req_reg,      req_next;
    logic          gen_reg,      gen_next;
    logic [KW-1:0] k_reg,        k_next;
    logic          s1_valid_reg, s1_valid_next;
    logic [KW-1:0] s1_k_reg,     s1_k_next;
    sel_t          s1_sel_reg,   s1_sel_next;
    logic [7:0]    s1_hdr_reg,   s1_hdr_next;
    logic [1:0]    s1_kind_reg,  s1_kind_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic [KW-1:0] out_k_reg,    out_k_next;
    logic [1:0]    out_kind_reg, out_kind_next;
    logic          out_last_reg, out_last_next;

    logic               out_free;
    logic               move1;
    logic               issue;
    logic [COUNT_W-1:0] k_ext;
    logic [COUNT_W-1:0] rel;
    logic               is_hdr;
    logic               is_data;
    logic [BASE_W-1:0]  addr_sum;

    assign out_free = !out_valid_reg || tx.ready;
    assign move1    = s1_valid_reg && out_free;
    assign issue    = gen_reg && (!s1_valid_reg || move1);

    // position relative to the first payload byte of the packet
    assign k_ext    = COUNT_W'(k_reg);
    assign rel      = k_ext - COUNT_W'(req_reg.hdr_len);
    assign is_hdr   = k_ext < COUNT_W'(req_reg.hdr_len);
    assign is_data  = !is_hdr && (rel < req_reg.count);
    assign addr_sum = req_reg.base + BASE_W'(rel);

    assign ram_re    = issue && is_data;
    assign ram_raddr = addr_sum[ADDR_W-1:0];
    assign idle      = !gen_reg && !s1_valid_reg;

    assign tx.valid       = out_valid_reg;
    assign tx.packet_byte = out_byte_reg;
    assign tx.byte_index  = 6'(out_k_reg);
    assign tx.packet_kind = out_kind_reg;
    assign tx.last_byte   = out_last_reg;

    always_comb
    begin
        req_next       = req_reg;
        gen_next       = gen_reg;
        k_next         = k_reg;
        s1_valid_next  = s1_valid_reg;
        s1_k_next      = s1_k_reg;
        s1_sel_next    = s1_sel_reg;
        s1_hdr_next    = s1_hdr_reg;
        s1_kind_next   = s1_kind_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_k_next     = out_k_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;

        // ram data lines up with the stage one item
        if (move1)
        begin
            out_valid_next = 1'b1;
            out_k_next     = s1_k_reg;
            out_kind_next  = s1_kind_reg;
            out_last_next  = (s1_k_reg == KW'(LAST_K));
            unique case (s1_sel_reg)
                SEL_HDR:  out_byte_next = s1_hdr_reg;
                SEL_DATA: out_byte_next = ram_rdata;
                default:  out_byte_next = 8'h00;
            endcase
        end
        else if (tx.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (issue)
        begin
            s1_valid_next = 1'b1;
            s1_k_next     = k_reg;
            s1_hdr_next   = req_reg.hdr[k_reg[2:0]];
            s1_kind_next  = req_reg.kind;
            if (is_hdr)
            begin
                s1_sel_next = SEL_HDR;
            end
            else if (is_data)
            begin
                s1_sel_next = SEL_DATA;
            end
            else
            begin
                s1_sel_next = SEL_ZERO;
            end
            k_next = k_reg + KW'(1);
            if (k_reg == KW'(LAST_K))
            begin
                gen_next = 1'b0;
            end
        end
        else if (move1)
        begin
            s1_valid_next = 1'b0;
        end

        if (req.start)
        begin
            req_next = req;
            gen_next = 1'b1;
            k_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg       <= 1'b0;
            k_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            gen_reg       <= gen_next;
            k_reg         <= k_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        s1_k_reg     <= s1_k_next;
        s1_sel_reg   <= s1_sel_next;
        s1_hdr_reg   <= s1_hdr_next;
        s1_kind_reg  <= s1_kind_next;
        out_byte_reg <= out_byte_next;
        out_k_reg    <= out_k_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

endmodule

`default_nettype wire

>>> rtl/ctaphid_response_packetizer.sv
// ctaphid response packetizer: message control, payload store and packet framer
// depends on ctp_pkg, ctp_if, ctp_ram, ctp_framer and assert_macros.svh
//
// usage
//   rx carries items: a header (channel, command, length), payload bytes, and
//   report-complete events; endpoint_ok tells whether a packet sent now is taken.
//   tx carries packets as PACKET_BYTES byte items, byte_index 0 first, last_byte
//   on the final one; packet_kind tells initial, continuation or busy refusal.
//   cfg_we/cfg_index/cfg_data write the error command and busy error code.
// timing
//   an item that sends nothing keeps rx.ready high; such items go back to back.
//   an item that sends a packet holds rx.ready low until the framer is idle:
//   while tx takes bytes, the framer walks one byte position a cycle through the
//   single read port of the payload store, then one registered stage to tx.
//   the request is registered in the framer; each byte then passes stage one.
// reset
//   all control state clears at once, no clearing pass; the payload store is
//   not cleared, only bytes written for the current message are read.
// stalls
//   tx.ready low stalls the framer once stage one is full; rx.ready stays
//   low until the packet's last position has left stage one, so nothing is lost.
`default_nettype none
`include "assert_macros.svh"

module ctaphid_response_packetizer #(
    parameter int PACKET_BYTES = 64,
    parameter int MAX_MESSAGE  = 7609
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    ctp_item_if.sink        rx,
    ctp_byte_if.source      tx,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data
);

    import ctp_pkg::*;

    localparam int AW        = $clog2(MAX_MESSAGE);
    localparam int LW        = $clog2(MAX_MESSAGE + 1);
    localparam int ROOM_INIT = PACKET_BYTES - 7;
    localparam int ROOM_CONT = PACKET_BYTES - 5;

    logic [6:0]  err_cmd_reg;
    logic [7:0]  busy_code_reg;

    logic [LW-1:0] stored_length_reg,   stored_length_next;
    logic [LW-1:0] load_count_reg,      load_count_next;
    logic          loading_reg,         loading_next;
    logic [LW-1:0] bytes_sent_reg,      bytes_sent_next;
    logic [31:0]   tx_channel_reg,      tx_channel_next;
    logic [6:0]    tx_command_reg,      tx_command_next;
    logic [6:0]    next_sequence_reg,   next_sequence_next;
    logic          sending_busy_reg,    sending_busy_next;
    logic          refusal_pending_reg, refusal_pending_next;
    logic [31:0]   refusal_channel_reg, refusal_channel_next;

    logic          accept;
    logic          fr_idle;
    pkt_req_t      req;
    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic [LW-1:0] lc_inc;
    logic [LW-1:0] init_len;
    logic [31:0]   init_ch;
    logic [6:0]    init_cmd;
    logic [LW-1:0] init_n;
    logic [LW-1:0] remaining;
    logic [LW-1:0] cont_n;
    logic [LW-1:0] sent_after;
    logic          do_initial;

    assign accept   = rx.valid && rx.ready;
    assign rx.ready = fr_idle;

    assign lc_inc     = load_count_reg + LW'(1);
    assign init_len   = (rx.cmd == CMD_HEADER) ? rx.message_length[LW-1:0] : stored_length_reg;
    assign init_ch    = (rx.cmd == CMD_HEADER) ? rx.channel_id : tx_channel_reg;
    assign init_cmd   = (rx.cmd == CMD_HEADER) ? rx.resp_command : tx_command_reg;
    assign init_n     = (init_len < LW'(ROOM_INIT)) ? init_len : LW'(ROOM_INIT);
    assign remaining  = stored_length_reg - bytes_sent_reg;
    assign cont_n     = (remaining < LW'(ROOM_CONT)) ? remaining : LW'(ROOM_CONT);
    assign sent_after = bytes_sent_reg + cont_n;

    // payload store write; no read can be in flight while an item is taken
    assign ram_we = accept && (rx.cmd == CMD_PAYLOAD) && loading_reg;

    function automatic logic [7:0][7:0] busy_hdr(input logic [31:0] ch,
                                                 input logic [6:0] ecmd,
                                                 input logic [7:0] code);
        logic [7:0][7:0] h;
        h    = '0;
        h[0] = ch[31:24];
        h[1] = ch[23:16];
        h[2] = ch[15:8];
        h[3] = ch[7:0];
        h[4] = {1'b1, ecmd};
        h[5] = 8'h00;
        h[6] = 8'h01;
        h[7] = code;
        return h;
    endfunction

    always_comb
    begin
        logic [15:0] len16;
        stored_length_next   = stored_length_reg;
        load_count_next      = load_count_reg;
        loading_next         = loading_reg;
        bytes_sent_next      = bytes_sent_reg;
        tx_channel_next      = tx_channel_reg;
        tx_command_next      = tx_command_reg;
        next_sequence_next   = next_sequence_reg;
        sending_busy_next    = sending_busy_reg;
        refusal_pending_next = refusal_pending_reg;
        refusal_channel_next = refusal_channel_reg;
        do_initial           = 1'b0;
        req                  = '0;
        len16                = 16'(init_len);

        if (accept)
        begin
            unique case (rx.cmd)
                CMD_HEADER:
                begin
                    if (sending_busy_reg)
                    begin
                        if (rx.endpoint_ok)
                        begin
                            req.start   = 1'b1;
                            req.kind    = KIND_BUSY;
                            req.hdr     = busy_hdr(rx.channel_id, err_cmd_reg, busy_code_reg);
                            req.hdr_len = HDR_LEN_BUSY;
                        end
                        else
                        begin
                            refusal_pending_next = 1'b1;
                            refusal_channel_next = rx.channel_id;
                        end
                    end
                    else if (rx.message_length > 16'(MAX_MESSAGE))
                    begin
                        loading_next = 1'b0;
                    end
                    else
                    begin
                        tx_channel_next    = rx.channel_id;
                        tx_command_next    = rx.resp_command;
                        stored_length_next = rx.message_length[LW-1:0];
                        load_count_next    = '0;
                        if (rx.message_length == 16'd0)
                        begin
                            loading_next = 1'b0;
                            do_initial   = 1'b1;
                        end
                        else
                        begin
                            loading_next = 1'b1;
                        end
                    end
                end
                CMD_PAYLOAD:
                begin
                    if (loading_reg)
                    begin
                        load_count_next = lc_inc;
                        if (lc_inc >= stored_length_reg)
                        begin
                            loading_next = 1'b0;
                            do_initial   = 1'b1;
                        end
                    end
                end
                CMD_REPORT:
                begin
                    if (refusal_pending_reg)
                    begin
                        refusal_pending_next = 1'b0;
                        if (rx.endpoint_ok)
                        begin
                            req.start   = 1'b1;
                            req.kind    = KIND_BUSY;
                            req.hdr     = busy_hdr(refusal_channel_reg, err_cmd_reg,
                                                   busy_code_reg);
                            req.hdr_len = HDR_LEN_BUSY;
                        end
                    end
                    else if (!sending_busy_reg)
                    begin
                        sending_busy_next = 1'b0;
                    end
                    else if (bytes_sent_reg >= stored_length_reg)
                    begin
                        sending_busy_next = 1'b0;
                    end
                    else
                    begin
                        bytes_sent_next    = sent_after;
                        next_sequence_next = next_sequence_reg + 7'd1;
                        if (!rx.endpoint_ok)
                        begin
                            sending_busy_next = 1'b0;
                        end
                        else
                        begin
                            sending_busy_next = sent_after < stored_length_reg;
                            req.start   = 1'b1;
                            req.kind    = KIND_CONT;
                            req.hdr[0]  = tx_channel_reg[31:24];
                            req.hdr[1]  = tx_channel_reg[23:16];
                            req.hdr[2]  = tx_channel_reg[15:8];
                            req.hdr[3]  = tx_channel_reg[7:0];
                            req.hdr[4]  = {1'b0, next_sequence_reg};
                            req.hdr_len = HDR_LEN_CONT;
                            req.count   = COUNT_W'(cont_n);
                            req.base    = BASE_W'(bytes_sent_reg);
                        end
                    end
                end
                default:
                begin
                    // unused command code: no effect
                    loading_next = loading_reg;
                end
            endcase
        end

        // initial packet, for an empty message or on its last payload byte
        if (do_initial)
        begin
            next_sequence_next = 7'd0;
            bytes_sent_next    = init_n;
            if (rx.endpoint_ok)
            begin
                sending_busy_next = init_n < init_len;
                req.start   = 1'b1;
                req.kind    = KIND_INITIAL;
                req.hdr[0]  = init_ch[31:24];
                req.hdr[1]  = init_ch[23:16];
                req.hdr[2]  = init_ch[15:8];
                req.hdr[3]  = init_ch[7:0];
                req.hdr[4]  = {1'b1, init_cmd};
                req.hdr[5]  = len16[15:8];
                req.hdr[6]  = len16[7:0];
                req.hdr_len = HDR_LEN_INIT;
                req.count   = COUNT_W'(init_n);
                req.base    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_cmd_reg         <= 7'd63;
            busy_code_reg       <= 8'd6;
            stored_length_reg   <= '0;
            load_count_reg      <= '0;
            loading_reg         <= 1'b0;
            bytes_sent_reg      <= '0;
            tx_channel_reg      <= '0;
            tx_command_reg      <= '0;
            next_sequence_reg   <= '0;
            sending_busy_reg    <= 1'b0;
            refusal_pending_reg <= 1'b0;
            refusal_channel_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ERROR_CMD: err_cmd_reg   <= cfg_data[6:0];
                    REG_BUSY_CODE: busy_code_reg <= cfg_data;
                    default:       busy_code_reg <= busy_code_reg;
                endcase
            end
            stored_length_reg   <= stored_length_next;
            load_count_reg      <= load_count_next;
            loading_reg         <= loading_next;
            bytes_sent_reg      <= bytes_sent_next;
            tx_channel_reg      <= tx_channel_next;
            tx_command_reg      <= tx_command_next;
            next_sequence_reg   <= next_sequence_next;
            sending_busy_reg    <= sending_busy_next;
            refusal_pending_reg <= refusal_pending_next;
            refusal_channel_reg <= refusal_channel_next;
        end
    end

    ctp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_MESSAGE)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (load_count_reg[AW-1:0]),
        .wdata (rx.payload_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ctp_framer #(
        .PACKET_BYTES (PACKET_BYTES),
        .ADDR_W       (AW)
    ) u_framer (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .idle      (fr_idle),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .tx        (tx)
    );

    `CTP_NEVER(a_no_write_during_read, clk, rst_n, ram_we && !fr_idle, "store written while framing")
    `CTP_ASSERT(a_busy_not_loading, clk, rst_n, sending_busy_reg |-> !loading_reg, "busy while loading")
    `CTP_ASSERT(a_busy_has_bytes, clk, rst_n, sending_busy_reg |-> (bytes_sent_reg < stored_length_reg), "busy with nothing left")
    `CTP_ASSERT(a_load_in_range, clk, rst_n, loading_reg |-> (load_count_reg < stored_length_reg), "load count past length")

endmodule

`default_nettype wire
